// ===== sv/adf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adf_pkg
// Shared types and codes of the adaptive deblocking edge filter.
// ----------------------------------------------------------------------------
package adf_pkg;

  localparam int unsigned NumLines = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;

  // eight pixels, byte k at offset k-4 from the edge
  typedef logic [7:0][7:0] line_t;

  localparam logic [1:0] MODE_NONE    = 2'd0;
  localparam logic [1:0] MODE_STRONG  = 2'd1;
  localparam logic [1:0] MODE_WEAK    = 2'd2;
  localparam logic [1:0] MODE_REDUCED = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_CLIP_LEFT  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_CLIP_RIGHT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_STEP_MULT  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SIDE_THR   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_OUTER_THR  = 3'd4;

endpackage

// ===== sv/adaptive_deblock_edge_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_deblock_edge_filter
// Filters one four-line edge segment: gradient decision, then strong or weak
// correction of each line, in a four-register pipeline.
// ----------------------------------------------------------------------------
// channel | direction | handshake                | payload
// in      | input     | in_valid_i / in_stall_o  | line_*_i, dither_*_i, flags
// out     | output    | out_valid_o / out_stall_i| out_line_*_o, applied_mode_o
// cfg     | input     | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// One segment enters per cycle while the output is not stalled; each passes
// to the output register through four register stages (decision and step
// products, first strong taps or the weak correction, second strong taps,
// outermost strong taps).
// Reset clears the valid bits and the configuration registers.
// A stalled output freezes every stage at once; in_stall_o follows it.
// ----------------------------------------------------------------------------
module adaptive_deblock_edge_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [adf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [adf_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [63:0]                   line_0_i,
  input  logic [63:0]                   line_1_i,
  input  logic [63:0]                   line_2_i,
  input  logic [63:0]                   line_3_i,
  input  logic [31:0]                   dither_left_lanes_i,
  input  logic [31:0]                   dither_right_lanes_i,
  input  logic                          is_chroma_i,
  input  logic                          is_block_edge_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [63:0]                   out_line_0_o,
  output logic [63:0]                   out_line_1_o,
  output logic [63:0]                   out_line_2_o,
  output logic [63:0]                   out_line_3_o,
  output logic [1:0]                    applied_mode_o
);
  import adf_pkg::*;

  // --------------------------------------------------------------------------
  // helpers
  function automatic logic [7:0] clip_f(logic signed [12:0] v);
    if (v < 13'sd0) return 8'd0;
    if (v > 13'sd255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic logic signed [12:0] clamp_f(logic signed [12:0] v, logic [8:0] l);
    logic signed [12:0] lim;
    lim = $signed({4'b0, l});
    if (v < -lim) return -lim;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic logic [12:0] abs_f(logic signed [12:0] v);
    return (v < 13'sd0) ? 13'(-v) : 13'(v);
  endfunction

  // weighted five-tap smoothing, result >> 7
  function automatic logic [8:0] sm_f(logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                      logic [7:0] d, logic [7:0] e, logic [7:0] m1,
                                      logic [7:0] m2, logic [7:0] add);
    logic [10:0] s;
    logic [15:0] v;
    s = {3'b0, a} + {3'b0, b} + {3'b0, c} + {3'b0, d} + {3'b0, e};
    v = ({5'b0, s} * 16'd26) - {8'b0, m1} - {8'b0, m2} + {8'b0, add};
    return v[15:7];
  endfunction

  function automatic logic in_rng_f(logic [7:0] x, logic [8:0] p, logic [8:0] v88);
    logic signed [10:0] d;
    logic signed [10:0] lim;
    d   = $signed({3'b0, x}) - $signed({2'b0, p});
    lim = $signed({2'b0, v88});
    return (d >= -lim) && (d <= lim);
  endfunction

  function automatic line_t strong1_f(line_t x, logic sfl, logic [8:0] v88,
                                      logic [7:0] dl, logic [7:0] dr);
    logic [8:0] p0;
    logic [8:0] p1;
    line_t      r;
    r  = x;
    p0 = sm_f(x[1], x[2], x[3], x[4], x[5], x[5], x[1], dl);
    p1 = sm_f(x[3], x[4], x[5], x[6], x[7], x[7], x[3], dr);
    if (!sfl) begin
      r[3] = p0[7:0];
      r[4] = p1[7:0];
    end else begin
      r[3] = in_rng_f(x[3], p0, v88) ? p0[7:0] : p1[7:0];
      r[4] = in_rng_f(x[4], p1, v88) ? p1[7:0] : r[3];
    end
    return r;
  endfunction

  function automatic line_t strong2_f(line_t x, logic sfl, logic [8:0] v88,
                                      logic [7:0] dl, logic [7:0] dr);
    logic [8:0] p0;
    logic [8:0] p1;
    line_t      r;
    r  = x;
    p0 = sm_f(x[0], x[1], x[2], x[3], x[4], x[4], x[0], dl);
    p1 = sm_f(x[3], x[4], x[5], x[6], x[7], x[7], x[3], dr);
    if (!sfl) begin
      r[2] = p0[7:0];
      r[5] = p1[7:0];
    end else begin
      r[2] = in_rng_f(x[2], p0, v88) ? p0[7:0] : 8'(x[2] + v88[7:0]);
      r[5] = in_rng_f(x[5], p1, v88) ? p1[7:0] : 8'(x[5] + v88[7:0]);
    end
    return r;
  endfunction

  function automatic line_t strong3_f(line_t x);
    logic [8:0] p0;
    logic [8:0] p1;
    line_t      r;
    r    = x;
    p0   = sm_f(x[0], x[1], x[2], x[3], x[3], x[3], x[1], 8'd64);
    p1   = sm_f(x[4], x[5], x[6], x[7], x[4], x[4], x[6], 8'd64);
    r[1] = p0[7:0];
    r[6] = p1[7:0];
    return r;
  endfunction

  function automatic line_t weak_f(line_t x, logic f0, logic f1, logic [7:0] l0,
                                   logic [7:0] l1, logic [8:0] l2, logic [4:0] thr);
    logic signed [12:0] a1, a2, a3, a4, a5, a6;
    logic signed [12:0] tp, diff, t;
    logic signed [12:0] g0, g1, g2, g3;
    line_t              r;
    a1 = $signed({5'b0, x[1]});
    a2 = $signed({5'b0, x[2]});
    a3 = $signed({5'b0, x[3]});
    a4 = $signed({5'b0, x[4]});
    a5 = $signed({5'b0, x[5]});
    a6 = $signed({5'b0, x[6]});
    r  = x;
    tp = a3 - a4;
    if (f0 && f1) diff = (a2 - a5 + (tp <<< 2) + 13'sd4) >>> 3;
    else          diff = (tp + 13'sd1) >>> 1;
    diff = clamp_f(diff, l2);
    r[3] = clip_f(a3 + diff);
    r[4] = clip_f(a4 - diff);
    g0 = a2 - a3;
    g1 = a2 - a1;
    g2 = a5 - a4;
    g3 = a5 - a6;
    if (f0 && (abs_f(g1) <= {8'b0, thr})) begin
      t    = (g0 + g1 - diff) >>> 1;
      r[2] = clip_f(a2 - clamp_f(t, {1'b0, l1}));
    end
    if (f1 && (abs_f(g3) <= {8'b0, thr})) begin
      t    = (g2 + g3 + diff) >>> 1;
      r[5] = clip_f(a5 - clamp_f(t, {1'b0, l0}));
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // configuration
  logic [7:0] clip_l_q, clip_r_q, side_thr_q;
  logic [9:0] mult_q;
  logic [4:0] outer_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_l_q    <= '0;
      clip_r_q    <= '0;
      mult_q      <= '0;
      side_thr_q  <= '0;
      outer_thr_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CLIP_LEFT:  clip_l_q    <= cfg_wdata_i[7:0];
        REG_CLIP_RIGHT: clip_r_q    <= cfg_wdata_i[7:0];
        REG_STEP_MULT:  mult_q      <= cfg_wdata_i;
        REG_SIDE_THR:   side_thr_q  <= cfg_wdata_i[7:0];
        REG_OUTER_THR:  outer_thr_q <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pipeline control: a held result freezes every stage
  logic en;
  logic out_v_q;
  assign en         = !(out_v_q && out_stall_i);
  assign in_stall_o = !en;

  // --------------------------------------------------------------------------
  // stage 1: gradient decision and step products
  line_t ln_in [NumLines];
  assign ln_in[0] = line_0_i;
  assign ln_in[1] = line_1_i;
  assign ln_in[2] = line_2_i;
  assign ln_in[3] = line_3_i;

  logic [1:0] mode_d;
  logic       wf0_d, wf1_d;
  logic [7:0] wl0_d, wl1_d;
  logic [8:0] wl2_d, v88_d;
  logic       skip_s_d [NumLines];
  logic       skip_w_d [NumLines];
  logic       sfl_d    [NumLines];

  always_comb begin
    logic signed [12:0] s0, s1, s2, s3;
    logic [9:0]         thr4;
    logic               ll0_hi, ll1_hi, f0, f1;
    logic [9:0]         vsum;
    logic [7:0]         dx;
    logic [17:0]        prod;
    logic [10:0]        tt;
    s0 = '0; s1 = '0; s2 = '0; s3 = '0;
    for (int i = 0; i < NumLines; i++) begin
      s0 = s0 + $signed({5'b0, ln_in[i][2]}) - $signed({5'b0, ln_in[i][3]});
      s1 = s1 + $signed({5'b0, ln_in[i][2]}) - $signed({5'b0, ln_in[i][1]});
      s2 = s2 + $signed({5'b0, ln_in[i][5]}) - $signed({5'b0, ln_in[i][4]});
      s3 = s3 + $signed({5'b0, ln_in[i][5]}) - $signed({5'b0, ln_in[i][6]});
    end
    thr4   = {side_thr_q, 2'b00};
    ll0_hi = abs_f(s0) < {3'b0, thr4};
    ll1_hi = abs_f(s2) < {3'b0, thr4};
    f0     = ll0_hi && is_block_edge_i && (abs_f(s1) < {8'b0, outer_thr_q});
    f1     = ll1_hi && is_block_edge_i && (abs_f(s3) < {8'b0, outer_thr_q});
    vsum   = {2'b0, clip_l_q} + {2'b0, clip_r_q}
           + (ll0_hi ? 10'd3 : 10'd1) + (ll1_hi ? 10'd3 : 10'd1);
    v88_d  = vsum[9:1];
    if (!ll0_hi && !ll1_hi) begin
      mode_d = MODE_NONE;
    end else if (f0 && f1) begin
      mode_d = MODE_STRONG;
    end else if (ll0_hi && ll1_hi) begin
      mode_d = MODE_WEAK;
    end else begin
      mode_d = MODE_REDUCED;
    end
    if (mode_d == MODE_WEAK) begin
      wf0_d = 1'b1;
      wf1_d = 1'b1;
      wl0_d = clip_l_q;
      wl1_d = clip_r_q;
      wl2_d = v88_d;
    end else begin
      wf0_d = ll0_hi;
      wf1_d = ll1_hi;
      wl0_d = {1'b0, clip_l_q[7:1]};
      wl1_d = {1'b0, clip_r_q[7:1]};
      wl2_d = {1'b0, v88_d[8:1]};
    end
    for (int i = 0; i < NumLines; i++) begin
      dx          = (ln_in[i][4] > ln_in[i][3]) ? 8'(ln_in[i][4] - ln_in[i][3])
                                                : 8'(ln_in[i][3] - ln_in[i][4]);
      prod        = {8'b0, mult_q} * {10'b0, dx};
      tt          = prod[17:7];
      skip_s_d[i] = (dx == 8'd0) || (tt > 11'd1);
      skip_w_d[i] = (dx == 8'd0) || (tt > 11'd3) || (wf0_d && wf1_d && tt > 11'd2);
      sfl_d[i]    = tt[0];
    end
  end

  logic       v1_q;
  line_t      ln1_q [NumLines];
  logic [31:0] dl1_q, dr1_q;
  logic       chroma1_q;
  logic [1:0] mode1_q;
  logic       wf0_q, wf1_q;
  logic [7:0] wl0_q, wl1_q;
  logic [8:0] wl2_q, v88_1_q;
  logic       skip_s_q [NumLines];
  logic       skip_w_q [NumLines];
  logic       sfl1_q   [NumLines];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ln1_q     <= ln_in;
      dl1_q     <= dither_left_lanes_i;
      dr1_q     <= dither_right_lanes_i;
      chroma1_q <= is_chroma_i;
      mode1_q   <= mode_d;
      wf0_q     <= wf0_d;
      wf1_q     <= wf1_d;
      wl0_q     <= wl0_d;
      wl1_q     <= wl1_d;
      wl2_q     <= wl2_d;
      v88_1_q   <= v88_d;
      skip_s_q  <= skip_s_d;
      skip_w_q  <= skip_w_d;
      sfl1_q    <= sfl_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: first strong taps, or the whole weak correction
  line_t ln2_d [NumLines];
  logic  do2_d [NumLines];

  always_comb begin
    for (int i = 0; i < NumLines; i++) begin
      ln2_d[i] = ln1_q[i];
      do2_d[i] = 1'b0;
      unique case (mode1_q)
        MODE_STRONG: begin
          if (!skip_s_q[i]) begin
            do2_d[i] = 1'b1;
            ln2_d[i] = strong1_f(ln1_q[i], sfl1_q[i], v88_1_q,
                                 dl1_q[8*i +: 8], dr1_q[8*i +: 8]);
          end
        end
        MODE_WEAK, MODE_REDUCED: begin
          if (!skip_w_q[i])
            ln2_d[i] = weak_f(ln1_q[i], wf0_q, wf1_q, wl0_q, wl1_q, wl2_q, outer_thr_q);
        end
        default: ;
      endcase
    end
  end

  logic        v2_q;
  line_t       ln2_q [NumLines];
  logic [31:0] dl2_q, dr2_q;
  logic        chroma2_q;
  logic [1:0]  mode2_q;
  logic [8:0]  v88_2_q;
  logic        do2_q  [NumLines];
  logic        sfl2_q [NumLines];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ln2_q     <= ln2_d;
      dl2_q     <= dl1_q;
      dr2_q     <= dr1_q;
      chroma2_q <= chroma1_q;
      mode2_q   <= mode1_q;
      v88_2_q   <= v88_1_q;
      do2_q     <= do2_d;
      sfl2_q    <= sfl1_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: second strong taps, reading the updated inner pixels
  line_t ln3_d [NumLines];

  always_comb begin
    for (int i = 0; i < NumLines; i++) begin
      if (do2_q[i])
        ln3_d[i] = strong2_f(ln2_q[i], sfl2_q[i], v88_2_q,
                             dl2_q[8*i +: 8], dr2_q[8*i +: 8]);
      else
        ln3_d[i] = ln2_q[i];
    end
  end

  logic       v3_q;
  line_t      ln3_q [NumLines];
  logic       chroma3_q;
  logic [1:0] mode3_q;
  logic       do3_q [NumLines];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ln3_q     <= ln3_d;
      chroma3_q <= chroma2_q;
      mode3_q   <= mode2_q;
      do3_q     <= do2_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: outermost strong taps (luma only) into the output register
  line_t ln4_d [NumLines];

  always_comb begin
    for (int i = 0; i < NumLines; i++) begin
      if (do3_q[i] && !chroma3_q) ln4_d[i] = strong3_f(ln3_q[i]);
      else                        ln4_d[i] = ln3_q[i];
    end
  end

  line_t      out_ln_q [NumLines];
  logic [1:0] out_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_ln_q   <= ln4_d;
      out_mode_q <= mode3_q;
    end
  end

  assign out_valid_o    = out_v_q;
  assign out_line_0_o   = out_ln_q[0];
  assign out_line_1_o   = out_ln_q[1];
  assign out_line_2_o   = out_ln_q[2];
  assign out_line_3_o   = out_ln_q[3];
  assign applied_mode_o = out_mode_q;

endmodule

// ===== dv/deblock_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deblock_checker
// Watches the segment and result channels and the register port of the
// edge filter. Predicts each filtered segment from the accepted input and the
// current register values, and compares results in order against that.
// ----------------------------------------------------------------------------
module deblock_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [adf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [adf_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [63:0]                  line_0_i,
  input  logic [63:0]                  line_1_i,
  input  logic [63:0]                  line_2_i,
  input  logic [63:0]                  line_3_i,
  input  logic [31:0]                  dither_left_lanes_i,
  input  logic [31:0]                  dither_right_lanes_i,
  input  logic                         is_chroma_i,
  input  logic                         is_block_edge_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [63:0]                  out_line_0_i,
  input  logic [63:0]                  out_line_1_i,
  input  logic [63:0]                  out_line_2_i,
  input  logic [63:0]                  out_line_3_i,
  input  logic [1:0]                   applied_mode_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import adf_pkg::*;

  typedef int px_t [8];

  typedef struct packed {
    logic [3:0][63:0] lines;
    logic [1:0]       mode;
  } segment_t;

  segment_t filtered_q[$];

  logic [7:0] clip_left, clip_right, side_thr;
  logic [9:0] step_mult;
  logic [4:0] outer_thr;

  function automatic int iabs(int v);
    return v < 0 ? -v : v;
  endfunction

  function automatic int clampi(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // five-tap sum weighted by 26, less two pixels; indices are array positions
  function automatic int smooth(px_t x, int first, int last, int sub);
    return 26 * (x[first] + x[first+1] + x[first+2] + x[first+3] + x[last])
           - x[last] - x[sub];
  endfunction

  function automatic px_t weak_line(px_t x, bit f0, bit f1, int mult, int l0, int l1,
                                    int l2, int thr1, int s0, int s1, int s2, int s3);
    int t, diff;
    t = x[4] - x[3];
    if (t == 0) return x;
    t = (mult * iabs(t)) >>> 7;
    if (t > 3) return x;
    if (f0 && f1 && t > 2) return x;
    t = x[3] - x[4];
    if (f0 && f1) diff = (x[2] - x[5] + t * 4 + 4) >>> 3;
    else          diff = (t + 1) >>> 1;
    diff = clampi(diff, -l2, l2);
    x[3] = clampi(x[3] + diff, 0, 255);
    x[4] = clampi(x[4] - diff, 0, 255);
    if (iabs(s1) <= thr1 && f0) begin
      t = (s0 + s1 - diff) >>> 1;
      x[2] = clampi(x[2] - clampi(t, -l1, l1), 0, 255);
    end
    if (iabs(s3) <= thr1 && f1) begin
      t = (s2 + s3 + diff) >>> 1;
      x[5] = clampi(x[5] - clampi(t, -l0, l0), 0, 255);
    end
    return x;
  endfunction

  // taps are updated in order, so later taps see already filtered pixels
  function automatic px_t strong_line(px_t x, int mult, int v88, int dl, int dr,
                                      bit chroma);
    int t, sflag, p0, p1, d;
    t = x[4] - x[3];
    if (t == 0) return x;
    sflag = (mult * iabs(t)) >>> 7;
    if (sflag > 1) return x;
    p0 = (smooth(x, 1, 5, 1) + dl) >>> 7;
    p1 = (smooth(x, 3, 7, 3) + dr) >>> 7;
    if (sflag == 0) begin
      x[3] = p0 & 255;
      x[4] = p1 & 255;
    end else begin
      d = x[3] - p0;
      x[3] = (d >= -v88 && d <= v88) ? (p0 & 255) : (p1 & 255);
      d = x[4] - p1;
      x[4] = (d >= -v88 && d <= v88) ? (p1 & 255) : x[3];
    end
    p0 = (smooth(x, 0, 4, 0) + dl) >>> 7;
    p1 = (smooth(x, 3, 7, 3) + dr) >>> 7;
    if (sflag == 0) begin
      x[2] = p0 & 255;
      x[5] = p1 & 255;
    end else begin
      d = x[2] - p0;
      x[2] = (d >= -v88 && d <= v88) ? (p0 & 255) : ((x[2] + v88) & 255);
      d = x[5] - p1;
      x[5] = (d >= -v88 && d <= v88) ? (p1 & 255) : ((x[5] + v88) & 255);
    end
    if (!chroma) begin
      x[1] = ((smooth(x, 0, 3, 1) + 64) >>> 7) & 255;
      x[6] = ((smooth(x, 4, 4, 6) + 64) >>> 7) & 255;
    end
    return x;
  endfunction

  function automatic segment_t filter_segment(logic [3:0][63:0] ln, logic [31:0] dlv,
                                              logic [31:0] drv, bit chroma, bit blk_edge);
    px_t      x [4];
    int       g [4][4];
    int       s0, s1, s2, s3, lim0, lim1, mult, thr0, thr1, ll0, ll1, v88;
    bit       f0, f1;
    segment_t res;
    s0 = 0; s1 = 0; s2 = 0; s3 = 0;
    lim0 = clip_left; lim1 = clip_right; mult = step_mult;
    thr0 = side_thr;  thr1 = outer_thr;
    ll0 = 3; ll1 = 3; f0 = 1; f1 = 1;
    res.mode = MODE_NONE;
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 8; k++) x[i][k] = ln[i][8*k +: 8];
      g[i][0] = x[i][2] - x[i][3];
      g[i][1] = x[i][2] - x[i][1];
      g[i][2] = x[i][5] - x[i][4];
      g[i][3] = x[i][5] - x[i][6];
      s0 += g[i][0]; s1 += g[i][1]; s2 += g[i][2]; s3 += g[i][3];
    end
    if (iabs(s0) >= thr0 * 4) begin ll0 = 1; f0 = 0; end
    if (iabs(s2) >= thr0 * 4) begin ll1 = 1; f1 = 0; end
    if (ll0 + ll1 != 2) begin
      if (!blk_edge) begin f0 = 0; f1 = 0; end
      if (f0 && iabs(s1) >= thr1) f0 = 0;
      if (f1 && iabs(s3) >= thr1) f1 = 0;
      v88 = (lim0 + lim1 + ll0 + ll1) >> 1;
      if (f0 && f1) begin
        res.mode = MODE_STRONG;
        for (int i = 0; i < 4; i++)
          x[i] = strong_line(x[i], mult, v88, dlv[8*i +: 8], drv[8*i +: 8], chroma);
      end else if (ll0 == 3 && ll1 == 3) begin
        res.mode = MODE_WEAK;
        for (int i = 0; i < 4; i++)
          x[i] = weak_line(x[i], 1, 1, mult, lim0, lim1, v88, thr1,
                           g[i][0], g[i][1], g[i][2], g[i][3]);
      end else begin
        res.mode = MODE_REDUCED;
        for (int i = 0; i < 4; i++)
          x[i] = weak_line(x[i], ll0 == 3, ll1 == 3, mult, lim0 >> 1, lim1 >> 1,
                           v88 >> 1, thr1, g[i][0], g[i][1], g[i][2], g[i][3]);
      end
    end
    for (int i = 0; i < 4; i++)
      for (int k = 0; k < 8; k++) res.lines[i][8*k +: 8] = x[i][k][7:0];
    return res;
  endfunction

  assign pending_o = filtered_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    segment_t exp_seg, got;
    if (!rst_ni) begin
      clip_left  <= '0;
      clip_right <= '0;
      step_mult  <= '0;
      side_thr   <= '0;
      outer_thr  <= '0;
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CLIP_LEFT:  clip_left  <= cfg_wdata_i[7:0];
          REG_CLIP_RIGHT: clip_right <= cfg_wdata_i[7:0];
          REG_STEP_MULT:  step_mult  <= cfg_wdata_i;
          REG_SIDE_THR:   side_thr   <= cfg_wdata_i[7:0];
          REG_OUTER_THR:  outer_thr  <= cfg_wdata_i[4:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        filtered_q.push_back(filter_segment({line_3_i, line_2_i, line_1_i, line_0_i},
                                            dither_left_lanes_i, dither_right_lanes_i,
                                            is_chroma_i, is_block_edge_i));
      if (out_valid_i && !out_stall_i) begin
        got.lines = {out_line_3_i, out_line_2_i, out_line_1_i, out_line_0_i};
        got.mode  = applied_mode_i;
        if (filtered_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: result with no segment outstanding: mode %0d", $realtime,
                     got.mode);
        end else begin
          exp_seg = filtered_q.pop_front();
          if (got !== exp_seg) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("%0t: mismatch, mode exp %0d got %0d", $realtime, exp_seg.mode,
                       got.mode);
              for (int i = 0; i < 4; i++)
                if (got.lines[i] !== exp_seg.lines[i])
                  $display("  line %0d exp %016h got %016h", i, exp_seg.lines[i],
                           got.lines[i]);
            end
          end
        end
      end
    end
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives edge segments and register settings into the deblocking filter under
// random sender gaps and receiver stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  import adf_pkg::*;

  localparam int WatchdogLimit = 5000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [63:0]         line_0 = '0, line_1 = '0, line_2 = '0, line_3 = '0;
  logic [31:0]         dither_l = '0, dither_r = '0;
  logic                is_chroma = 1'b0, is_block_edge = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [63:0]         out_line_0, out_line_1, out_line_2, out_line_3;
  logic [1:0]          applied_mode;
  int                  fail_count, pending;
  int                  sender_idle_pct = 0, stall_pct = 0;
  int                  segments_sent = 0, settings_used = 0, idle_cycles = 0;

  adaptive_deblock_edge_filter u_top (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .line_0_i(line_0), .line_1_i(line_1), .line_2_i(line_2), .line_3_i(line_3),
    .dither_left_lanes_i(dither_l), .dither_right_lanes_i(dither_r),
    .is_chroma_i(is_chroma), .is_block_edge_i(is_block_edge),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_line_0_o(out_line_0), .out_line_1_o(out_line_1),
    .out_line_2_o(out_line_2), .out_line_3_o(out_line_3),
    .applied_mode_o(applied_mode)
  );

  deblock_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .line_0_i(line_0), .line_1_i(line_1), .line_2_i(line_2), .line_3_i(line_3),
    .dither_left_lanes_i(dither_l), .dither_right_lanes_i(dither_r),
    .is_chroma_i(is_chroma), .is_block_edge_i(is_block_edge),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .out_line_0_i(out_line_0), .out_line_1_i(out_line_1),
    .out_line_2_i(out_line_2), .out_line_3_i(out_line_3),
    .applied_mode_i(applied_mode),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // end the run if no transaction moves on either channel for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_segment(logic [63:0] l0, logic [63:0] l1, logic [63:0] l2,
                              logic [63:0] l3, bit chroma, bit blk_edge);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    line_0        <= l0;
    line_1        <= l1;
    line_2        <= l2;
    line_3        <= l3;
    dither_l      <= $urandom;
    dither_r      <= $urandom;
    is_chroma     <= chroma;
    is_block_edge <= blk_edge;
    do @(posedge clk_i); while (in_stall);
    segments_sent++;
  endtask

  // one line: flat base, step across the edge, per-side noise
  function automatic logic [63:0] make_line(int base, int step, int nl, int nr);
    logic [63:0] ln;
    int v;
    for (int k = 0; k < 8; k++) begin
      v = base + (k >= 4 ? step : 0);
      v += (k < 4) ? $urandom_range(2 * nl) - nl : $urandom_range(2 * nr) - nr;
      ln[8*k +: 8] = (v < 0) ? 8'd0 : (v > 255 ? 8'd255 : v[7:0]);
    end
    return ln;
  endfunction

  // style: 0 noise, 1 smooth edge, 2 one rough side, 3 near saturation
  task automatic send_shaped(int style);
    logic [63:0] ln [4];
    int base, step, amp, nl, nr;
    base = (style == 3) ? ($urandom_range(1) ? $urandom_range(245, 255)
                                             : $urandom_range(0, 10))
                        : $urandom_range(255);
    amp  = $urandom_range(1) ? 3 : 12;
    step = $urandom_range(2 * amp) - amp;
    nl   = $urandom_range(2);
    nr   = $urandom_range(2);
    if (style == 2) begin
      if ($urandom_range(1)) nl = $urandom_range(10, 60);
      else nr = $urandom_range(10, 60);
    end
    for (int i = 0; i < 4; i++)
      ln[i] = (style == 0) ? {$urandom, $urandom}
                           : make_line(base + $urandom_range(2) - 1, step, nl, nr);
    send_segment(ln[0], ln[1], ln[2], ln[3], $urandom_range(1), $urandom_range(1) != 0);
  endtask

  task automatic write_settings(int cl, int cr, int mult, int sthr, int othr);
    in_valid  <= 1'b0;
    // let the last accepted transaction reach the checker before draining
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_CLIP_LEFT;  cfg_wdata <= CfgDataW'(cl);   @(posedge clk_i);
    cfg_idx   <= REG_CLIP_RIGHT; cfg_wdata <= CfgDataW'(cr);   @(posedge clk_i);
    cfg_idx   <= REG_STEP_MULT;  cfg_wdata <= CfgDataW'(mult); @(posedge clk_i);
    cfg_idx   <= REG_SIDE_THR;   cfg_wdata <= CfgDataW'(sthr); @(posedge clk_i);
    cfg_idx   <= REG_OUTER_THR;  cfg_wdata <= CfgDataW'(othr); @(posedge clk_i);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int style;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: flat, saturated, extremes of each flag, each shape
    write_settings(6, 5, 40, 20, 6);
    send_segment('0, '0, '0, '0, 1'b0, 1'b1);
    send_segment('1, '1, '1, '1, 1'b1, 1'b1);
    send_segment('1, '0, '1, '0, 1'b0, 1'b0);
    send_segment(64'h0000_0000_FFFF_FFFF, 64'h0000_0000_FFFF_FFFF,
                 64'hFFFF_FFFF_0000_0000, 64'hFFFF_FFFF_0000_0000, 1'b1, 1'b0);
    for (int n = 0; n < 16; n++) send_shaped(n % 4);
    write_settings(0, 0, 1, 255, 31);
    repeat (4) send_shaped(1);

    for (int chunk = 0; chunk < 6; chunk++) begin
      case (chunk / 2)
        0:       begin sender_idle_pct = 19; stall_pct = 76; end
        1:       begin sender_idle_pct = 76; stall_pct = 19; end
        default: begin sender_idle_pct = 0;  stall_pct = 0;  end
      endcase
      case (chunk)
        1:       write_settings(255, 255, 1023, 255, 31);
        3:       write_settings(0, 0, 0, 0, 0);
        default: write_settings($urandom_range(15), $urandom_range(15),
                                $urandom_range(200), $urandom_range(1, 60),
                                $urandom_range(31));
      endcase
      for (int n = 0; n < 100; n++) begin
        style = $urandom_range(99);
        send_shaped(style < 15 ? 0 : (style < 60 ? 1 : (style < 85 ? 2 : 3)));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Filtered %0d edge segments under %0d register settings,", segments_sent,
             settings_used);
    $display("with random gaps and output stalls in three traffic phases.");
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/adf_pkg.sv
sv/adaptive_deblock_edge_filter.sv
dv/deblock_checker.sv
dv/tb.sv
